[design/assert_macros.svh]
// Assertion helpers shared by the command queue and the line executor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/g4fax_pkg.sv]
// ----------------------------------------------------------------------------
// g4fax_pkg
// Types, constants and code tables of the two-dimensional fax line decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package g4fax_pkg;

    localparam int MAX_WIDTH     = 8192;
    localparam int MAX_CODE_BITS = 13;
    localparam int IDX_W         = $clog2(MAX_WIDTH);
    localparam int POS_W         = 14;
    localparam int ROW_W         = 13;
    localparam int LEN_W         = 4;
    localparam int RUN_W         = 12;
    localparam int MODE_MAX_LEN  = 7;
    localparam int MAKEUP_MIN    = 64;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int TERM_COUNT    = 91;
    localparam int LONG_COUNT    = 13;

    localparam logic [POS_W-1:0] RUN_SAT      = 14'd16383;
    localparam logic [POS_W-1:0] WIDTH_RESET  = 14'd1728;
    localparam logic [POS_W-1:0] HEIGHT_RESET = 14'd1;
    localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(MAX_WIDTH);

    localparam logic CFG_LINE_WIDTH   = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // mode codes as {length, bits}
    localparam logic [16:0] MODE_V0    = {4'd1, 13'b1};
    localparam logic [16:0] MODE_VR1   = {4'd3, 13'b011};
    localparam logic [16:0] MODE_VL1   = {4'd3, 13'b010};
    localparam logic [16:0] MODE_HORIZ = {4'd3, 13'b001};
    localparam logic [16:0] MODE_PASS  = {4'd4, 13'b0001};
    localparam logic [16:0] MODE_VR2   = {4'd6, 13'b000011};
    localparam logic [16:0] MODE_VL2   = {4'd6, 13'b000010};
    localparam logic [16:0] MODE_VR3   = {4'd7, 13'b0000011};
    localparam logic [16:0] MODE_VL3   = {4'd7, 13'b0000010};

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_TRUNC
    } t_status;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_VERT,
        CMD_RUN,
        CMD_ERR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic signed [2:0] delta;
        logic [POS_W-1:0]  run;
        logic              second;
        logic              last;
        t_status           status;
    } t_cmd;

    typedef struct packed {
        logic idle;
        logic color;
        logic rows_done;
    } t_back_stat;

    typedef enum logic [2:0] {
        FS_MODE,
        FS_SYNC,
        FS_RUN1,
        FS_RUN2,
        FS_HALT
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SCAN_RD,
        BS_SCAN_CMP,
        BS_B2_RD,
        BS_B2_CMP,
        BS_EMIT
    } t_back_state;

    typedef struct packed {
        logic [LEN_W-1:0]         len;
        logic [MAX_CODE_BITS-1:0] pat;
        logic [RUN_W-1:0]         run;
    } t_code_entry;

    typedef struct packed {
        logic             hit;
        logic             prefix;
        logic [RUN_W-1:0] run;
    } t_lookup;

    localparam t_code_entry WHITE_TAB [TERM_COUNT] = '{
        '{4'd8, 13'b00110101, 12'd0}, '{4'd6, 13'b000111, 12'd1},
        '{4'd4, 13'b0111, 12'd2}, '{4'd4, 13'b1000, 12'd3},
        '{4'd4, 13'b1011, 12'd4}, '{4'd4, 13'b1100, 12'd5},
        '{4'd4, 13'b1110, 12'd6}, '{4'd4, 13'b1111, 12'd7},
        '{4'd5, 13'b10011, 12'd8}, '{4'd5, 13'b10100, 12'd9},
        '{4'd5, 13'b00111, 12'd10}, '{4'd5, 13'b01000, 12'd11},
        '{4'd6, 13'b001000, 12'd12}, '{4'd6, 13'b000011, 12'd13},
        '{4'd6, 13'b110100, 12'd14}, '{4'd6, 13'b110101, 12'd15},
        '{4'd6, 13'b101010, 12'd16}, '{4'd6, 13'b101011, 12'd17},
        '{4'd7, 13'b0100111, 12'd18}, '{4'd7, 13'b0001100, 12'd19},
        '{4'd7, 13'b0001000, 12'd20}, '{4'd7, 13'b0010111, 12'd21},
        '{4'd7, 13'b0000011, 12'd22}, '{4'd7, 13'b0000100, 12'd23},
        '{4'd7, 13'b0101000, 12'd24}, '{4'd7, 13'b0101011, 12'd25},
        '{4'd7, 13'b0010011, 12'd26}, '{4'd7, 13'b0100100, 12'd27},
        '{4'd7, 13'b0011000, 12'd28}, '{4'd8, 13'b00000010, 12'd29},
        '{4'd8, 13'b00000011, 12'd30}, '{4'd8, 13'b00011010, 12'd31},
        '{4'd8, 13'b00011011, 12'd32}, '{4'd8, 13'b00010010, 12'd33},
        '{4'd8, 13'b00010011, 12'd34}, '{4'd8, 13'b00010100, 12'd35},
        '{4'd8, 13'b00010101, 12'd36}, '{4'd8, 13'b00010110, 12'd37},
        '{4'd8, 13'b00010111, 12'd38}, '{4'd8, 13'b00101000, 12'd39},
        '{4'd8, 13'b00101001, 12'd40}, '{4'd8, 13'b00101010, 12'd41},
        '{4'd8, 13'b00101011, 12'd42}, '{4'd8, 13'b00101100, 12'd43},
        '{4'd8, 13'b00101101, 12'd44}, '{4'd8, 13'b00000100, 12'd45},
        '{4'd8, 13'b00000101, 12'd46}, '{4'd8, 13'b00001010, 12'd47},
        '{4'd8, 13'b00001011, 12'd48}, '{4'd8, 13'b01010010, 12'd49},
        '{4'd8, 13'b01010011, 12'd50}, '{4'd8, 13'b01010100, 12'd51},
        '{4'd8, 13'b01010101, 12'd52}, '{4'd8, 13'b00100100, 12'd53},
        '{4'd8, 13'b00100101, 12'd54}, '{4'd8, 13'b01011000, 12'd55},
        '{4'd8, 13'b01011001, 12'd56}, '{4'd8, 13'b01011010, 12'd57},
        '{4'd8, 13'b01011011, 12'd58}, '{4'd8, 13'b01001010, 12'd59},
        '{4'd8, 13'b01001011, 12'd60}, '{4'd8, 13'b00110010, 12'd61},
        '{4'd8, 13'b00110011, 12'd62}, '{4'd8, 13'b00110100, 12'd63},
        '{4'd5, 13'b11011, 12'd64}, '{4'd5, 13'b10010, 12'd128},
        '{4'd6, 13'b010111, 12'd192}, '{4'd7, 13'b0110111, 12'd256},
        '{4'd8, 13'b00110110, 12'd320}, '{4'd8, 13'b00110111, 12'd384},
        '{4'd8, 13'b01100100, 12'd448}, '{4'd8, 13'b01100101, 12'd512},
        '{4'd8, 13'b01101000, 12'd576}, '{4'd8, 13'b01100111, 12'd640},
        '{4'd9, 13'b011001100, 12'd704}, '{4'd9, 13'b011001101, 12'd768},
        '{4'd9, 13'b011010010, 12'd832}, '{4'd9, 13'b011010011, 12'd896},
        '{4'd9, 13'b011010100, 12'd960}, '{4'd9, 13'b011010101, 12'd1024},
        '{4'd9, 13'b011010110, 12'd1088}, '{4'd9, 13'b011010111, 12'd1152},
        '{4'd9, 13'b011011000, 12'd1216}, '{4'd9, 13'b011011001, 12'd1280},
        '{4'd9, 13'b011011010, 12'd1344}, '{4'd9, 13'b011011011, 12'd1408},
        '{4'd9, 13'b010011000, 12'd1472}, '{4'd9, 13'b010011001, 12'd1536},
        '{4'd9, 13'b010011010, 12'd1600}, '{4'd6, 13'b011000, 12'd1664},
        '{4'd9, 13'b010011011, 12'd1728}
    };

    localparam t_code_entry BLACK_TAB [TERM_COUNT] = '{
        '{4'd10, 13'b0000110111, 12'd0}, '{4'd3, 13'b010, 12'd1},
        '{4'd2, 13'b11, 12'd2}, '{4'd2, 13'b10, 12'd3},
        '{4'd3, 13'b011, 12'd4}, '{4'd4, 13'b0011, 12'd5},
        '{4'd4, 13'b0010, 12'd6}, '{4'd5, 13'b00011, 12'd7},
        '{4'd6, 13'b000101, 12'd8}, '{4'd6, 13'b000100, 12'd9},
        '{4'd7, 13'b0000100, 12'd10}, '{4'd7, 13'b0000101, 12'd11},
        '{4'd7, 13'b0000111, 12'd12}, '{4'd8, 13'b00000100, 12'd13},
        '{4'd8, 13'b00000111, 12'd14}, '{4'd9, 13'b000011000, 12'd15},
        '{4'd10, 13'b0000010111, 12'd16}, '{4'd10, 13'b0000011000, 12'd17},
        '{4'd10, 13'b0000001000, 12'd18}, '{4'd11, 13'b00001100111, 12'd19},
        '{4'd11, 13'b00001101000, 12'd20}, '{4'd11, 13'b00001101100, 12'd21},
        '{4'd11, 13'b00000110111, 12'd22}, '{4'd11, 13'b00000101000, 12'd23},
        '{4'd11, 13'b00000010111, 12'd24}, '{4'd11, 13'b00000011000, 12'd25},
        '{4'd12, 13'b000011001010, 12'd26}, '{4'd12, 13'b000011001011, 12'd27},
        '{4'd12, 13'b000011001100, 12'd28}, '{4'd12, 13'b000011001101, 12'd29},
        '{4'd12, 13'b000001101000, 12'd30}, '{4'd12, 13'b000001101001, 12'd31},
        '{4'd12, 13'b000001101010, 12'd32}, '{4'd12, 13'b000001101011, 12'd33},
        '{4'd12, 13'b000011010010, 12'd34}, '{4'd12, 13'b000011010011, 12'd35},
        '{4'd12, 13'b000011010100, 12'd36}, '{4'd12, 13'b000011010101, 12'd37},
        '{4'd12, 13'b000011010110, 12'd38}, '{4'd12, 13'b000011010111, 12'd39},
        '{4'd12, 13'b000001101100, 12'd40}, '{4'd12, 13'b000001101101, 12'd41},
        '{4'd12, 13'b000011011010, 12'd42}, '{4'd12, 13'b000011011011, 12'd43},
        '{4'd12, 13'b000001010100, 12'd44}, '{4'd12, 13'b000001010101, 12'd45},
        '{4'd12, 13'b000001010110, 12'd46}, '{4'd12, 13'b000001010111, 12'd47},
        '{4'd12, 13'b000001100100, 12'd48}, '{4'd12, 13'b000001100101, 12'd49},
        '{4'd12, 13'b000001010010, 12'd50}, '{4'd12, 13'b000001010011, 12'd51},
        '{4'd12, 13'b000000100100, 12'd52}, '{4'd12, 13'b000000110111, 12'd53},
        '{4'd12, 13'b000000111000, 12'd54}, '{4'd12, 13'b000000100111, 12'd55},
        '{4'd12, 13'b000000101000, 12'd56}, '{4'd12, 13'b000001011000, 12'd57},
        '{4'd12, 13'b000001011001, 12'd58}, '{4'd12, 13'b000000101011, 12'd59},
        '{4'd12, 13'b000000101100, 12'd60}, '{4'd12, 13'b000001011010, 12'd61},
        '{4'd12, 13'b000001100110, 12'd62}, '{4'd12, 13'b000001100111, 12'd63},
        '{4'd10, 13'b0000001111, 12'd64}, '{4'd12, 13'b000011001000, 12'd128},
        '{4'd12, 13'b000011001001, 12'd192}, '{4'd12, 13'b000001011011, 12'd256},
        '{4'd12, 13'b000000110011, 12'd320}, '{4'd12, 13'b000000110100, 12'd384},
        '{4'd12, 13'b000000110101, 12'd448}, '{4'd13, 13'b0000001101100, 12'd512},
        '{4'd13, 13'b0000001101101, 12'd576}, '{4'd13, 13'b0000001001010, 12'd640},
        '{4'd13, 13'b0000001001011, 12'd704}, '{4'd13, 13'b0000001001100, 12'd768},
        '{4'd13, 13'b0000001001101, 12'd832}, '{4'd13, 13'b0000001110010, 12'd896},
        '{4'd13, 13'b0000001110011, 12'd960}, '{4'd13, 13'b0000001110100, 12'd1024},
        '{4'd13, 13'b0000001110101, 12'd1088}, '{4'd13, 13'b0000001110110, 12'd1152},
        '{4'd13, 13'b0000001110111, 12'd1216}, '{4'd13, 13'b0000001010010, 12'd1280},
        '{4'd13, 13'b0000001010011, 12'd1344}, '{4'd13, 13'b0000001010100, 12'd1408},
        '{4'd13, 13'b0000001010101, 12'd1472}, '{4'd13, 13'b0000001011010, 12'd1536},
        '{4'd13, 13'b0000001011011, 12'd1600}, '{4'd13, 13'b0000001100100, 12'd1664},
        '{4'd13, 13'b0000001100101, 12'd1728}
    };

    localparam t_code_entry LONG_TAB [LONG_COUNT] = '{
        '{4'd11, 13'b00000001000, 12'd1792}, '{4'd11, 13'b00000001100, 12'd1856},
        '{4'd11, 13'b00000001101, 12'd1920}, '{4'd12, 13'b000000010010, 12'd1984},
        '{4'd12, 13'b000000010011, 12'd2048}, '{4'd12, 13'b000000010100, 12'd2112},
        '{4'd12, 13'b000000010101, 12'd2176}, '{4'd12, 13'b000000010110, 12'd2240},
        '{4'd12, 13'b000000010111, 12'd2304}, '{4'd12, 13'b000000011100, 12'd2368},
        '{4'd12, 13'b000000011101, 12'd2432}, '{4'd12, 13'b000000011110, 12'd2496},
        '{4'd12, 13'b000000011111, 12'd2560}
    };

    function automatic t_lookup entry_check(input t_lookup acc, input t_code_entry e,
                                            input logic [LEN_W-1:0] len,
                                            input logic [MAX_CODE_BITS-1:0] bits);
        t_lookup r;
        logic [MAX_CODE_BITS-1:0] head;
        r = acc;
        if (e.len >= len) begin
            head = e.pat >> (e.len - len);
            if (head == bits) begin
                r.prefix = 1'b1;
                if (e.len == len) begin
                    r.hit = 1'b1;
                    r.run = e.run;
                end
            end
        end
        return r;
    endfunction

    function automatic t_lookup run_lookup(input logic black, input logic [LEN_W-1:0] len,
                                           input logic [MAX_CODE_BITS-1:0] bits);
        t_lookup r;
        r = '0;
        for (int k = 0; k < TERM_COUNT; k++) begin
            r = entry_check(r, black ? BLACK_TAB[k] : WHITE_TAB[k], len, bits);
        end
        for (int k = 0; k < LONG_COUNT; k++) begin
            r = entry_check(r, LONG_TAB[k], len, bits);
        end
        return r;
    endfunction

endpackage

[design/g4fax_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// g4fax_cmd_fifo
// Short command queue between the code decoder and the line executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module g4fax_cmd_fifo
    import g4fax_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd                  r_q [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full  = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule
`default_nettype wire

[design/g4fax_front.sv]
// ----------------------------------------------------------------------------
// g4fax_front
// Bit intake: shifts code bits, decodes mode and run codes, issues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module g4fax_front
    import g4fax_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire logic i_code_bit,
    input  wire logic i_stream_end,
    input  t_back_stat i_stat,
    input  wire logic i_full,
    input  wire logic i_empty,
    output logic      o_push,
    output t_cmd      o_cmd
);

    t_front_state r_state;
    t_front_state n_state;
    logic [MAX_CODE_BITS-1:0] r_code;
    logic [LEN_W-1:0]         r_len;
    logic [POS_W-1:0]         r_acc;
    logic                     r_color;

    logic [MAX_CODE_BITS-1:0] code_n;
    logic [LEN_W-1:0]         len_n;
    logic                     work;
    logic                     d_clear;
    logic                     d_halt;
    logic                     d_sync;
    logic                     d_term;
    logic                     d_makeup;
    logic [POS_W-1:0]         d_acc;
    logic [POS_W:0]           acc_sum;
    t_lookup                  lk;

    assign o_ready = (r_state == FS_HALT) || i_stat.rows_done
                     || ((r_state != FS_SYNC) && !i_full);
    assign work    = i_valid && o_ready && !i_stat.rows_done
                     && ((r_state == FS_MODE) || (r_state == FS_RUN1) || (r_state == FS_RUN2));
    assign code_n  = {r_code[MAX_CODE_BITS-2:0], i_code_bit};
    assign len_n   = r_len + 1'b1;
    assign lk      = run_lookup(r_color, len_n, code_n);
    assign acc_sum = {1'b0, r_acc} + (POS_W+1)'(lk.run);

    always_comb begin
        o_push   = 1'b0;
        o_cmd    = '0;
        d_clear  = 1'b0;
        d_halt   = 1'b0;
        d_sync   = 1'b0;
        d_term   = 1'b0;
        d_makeup = 1'b0;
        d_acc    = (acc_sum > {1'b0, RUN_SAT}) ? RUN_SAT : acc_sum[POS_W-1:0];
        o_cmd.last   = i_stream_end;
        o_cmd.second = (r_state == FS_RUN2);
        if (work && (r_state == FS_MODE)) begin
            d_clear = 1'b1;
            o_push  = 1'b1;
            o_cmd.kind = CMD_VERT;
            case ({len_n, code_n})
                MODE_V0:    o_cmd.delta = 3'sd0;
                MODE_VR1:   o_cmd.delta = 3'sd1;
                MODE_VL1:   o_cmd.delta = -3'sd1;
                MODE_VR2:   o_cmd.delta = 3'sd2;
                MODE_VL2:   o_cmd.delta = -3'sd2;
                MODE_VR3:   o_cmd.delta = 3'sd3;
                MODE_VL3:   o_cmd.delta = -3'sd3;
                MODE_PASS:  o_cmd.kind  = CMD_PASS;
                MODE_HORIZ: begin
                    if (i_stream_end) begin
                        o_cmd.kind   = CMD_ERR;
                        o_cmd.status = ST_TRUNC;
                    end else begin
                        o_push = 1'b0;
                        d_sync = 1'b1;
                    end
                end
                default: begin
                    d_clear = 1'b0;
                    o_cmd.kind = CMD_ERR;
                    if (len_n > LEN_W'(MODE_MAX_LEN)) begin
                        o_cmd.status = ST_INVALID;
                    end else if (i_stream_end) begin
                        o_cmd.status = ST_TRUNC;
                    end else begin
                        o_push = 1'b0;
                    end
                end
            endcase
            d_halt = o_push && (i_stream_end || (o_cmd.kind == CMD_ERR));
        end else if (work) begin
            if (lk.hit) begin
                d_clear = 1'b1;
                if (lk.run >= RUN_W'(MAKEUP_MIN)) begin
                    if (i_stream_end) begin
                        o_push       = 1'b1;
                        o_cmd.kind   = CMD_ERR;
                        o_cmd.status = ST_TRUNC;
                    end else begin
                        d_makeup = 1'b1;
                    end
                end else begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_RUN;
                    o_cmd.run  = d_acc;
                    d_term     = 1'b1;
                end
            end else begin
                o_cmd.kind = CMD_ERR;
                if ((len_n > LEN_W'(MAX_CODE_BITS)) || !lk.prefix) begin
                    o_push       = 1'b1;
                    o_cmd.status = ST_INVALID;
                end else if (i_stream_end) begin
                    o_push       = 1'b1;
                    o_cmd.status = ST_TRUNC;
                end
            end
            d_halt = o_push && (i_stream_end || (o_cmd.kind == CMD_ERR));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_MODE: begin
                if (work && d_halt) begin
                    n_state = FS_HALT;
                end else if (work && d_sync) begin
                    n_state = FS_SYNC;
                end
            end
            FS_SYNC: begin
                if (i_stat.idle && i_empty) begin
                    n_state = FS_RUN1;
                end
            end
            FS_RUN1: begin
                if (work && d_halt) begin
                    n_state = FS_HALT;
                end else if (work && d_term) begin
                    n_state = FS_RUN2;
                end
            end
            FS_RUN2: begin
                if (work && d_halt) begin
                    n_state = FS_HALT;
                end else if (work && d_term) begin
                    n_state = FS_MODE;
                end
            end
            FS_HALT: n_state = FS_HALT;
            default: n_state = FS_HALT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_MODE;
            r_code  <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_color <= 1'b0;
        end else begin
            r_state <= n_state;
            if (work) begin
                if (d_clear) begin
                    r_code <= '0;
                    r_len  <= '0;
                end else begin
                    r_code <= code_n;
                    r_len  <= len_n;
                end
                if (d_makeup) begin
                    r_acc <= d_acc;
                end else if (d_term || d_sync) begin
                    r_acc <= '0;
                end
                if (d_term && (r_state == FS_RUN1)) begin
                    r_color <= ~r_color;
                end
            end
            if ((r_state == FS_SYNC) && (n_state == FS_RUN1)) begin
                r_color <= i_stat.color;
            end
        end
    end

endmodule
`default_nettype wire

[design/g4fax_back.sv]
// ----------------------------------------------------------------------------
// g4fax_back
// Line executor: reference search, change lists, row swap and result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module g4fax_back
    import g4fax_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_pop,
    input  wire logic [POS_W-1:0] i_width,
    input  wire logic [POS_W-1:0] i_height,
    output t_back_stat            o_stat,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [POS_W-1:0]      o_run_start,
    output logic [POS_W-1:0]      o_run_end,
    output logic                  o_run_black,
    output logic [ROW_W-1:0]      o_run_row,
    output logic                  o_row_done,
    output logic [1:0]            o_status
);

    t_back_state r_state;
    t_back_state n_state;
    t_cmd             r_cmd;
    logic [POS_W-1:0] r_lp;
    logic             r_color;
    logic             r_fresh;
    logic [POS_W-1:0] r_row_count;
    logic             r_ref_sel;
    logic [POS_W-1:0] r_ref_count;
    logic [POS_W-1:0] r_cur_count;
    logic [POS_W-1:0] r_idx;
    logic [POS_W-1:0] r_re;
    logic             r_halt;

    logic [POS_W-1:0] r_mem0 [MAX_WIDTH];
    logic [POS_W-1:0] r_mem1 [MAX_WIDTH];
    logic [POS_W-1:0] r_rd0;
    logic [POS_W-1:0] r_rd1;

    logic             r_o_valid;
    logic [POS_W-1:0] r_o_start;
    logic [POS_W-1:0] r_o_end;
    logic             r_o_black;
    logic [ROW_W-1:0] r_o_row;
    logic             r_o_done;
    t_status          r_o_status;

    logic             rows_done;
    logic             out_free;
    logic             emit;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [POS_W-1:0] ref_data;
    logic [POS_W-1:0] v;
    logic             skip;
    logic             found;
    logic [POS_W:0]   run_sum;
    logic signed [POS_W+1:0] a1_s;
    logic [POS_W-1:0] rs;
    logic             moves;
    logic             do_push;
    logic [POS_W-1:0] cur_next;
    logic             row_end;

    assign rows_done = (r_row_count >= i_height);
    assign out_free  = !r_o_valid || i_ready;
    assign emit      = (r_state == BS_EMIT) && out_free;
    assign ref_data  = r_ref_sel ? r_rd1 : r_rd0;
    assign v         = (r_idx < r_ref_count) ? ref_data : i_width;
    assign skip      = r_fresh ? (v < r_lp) : (v <= r_lp);
    assign found     = (!skip && (r_idx[0] == r_color)) || (r_idx == r_ref_count);
    assign run_sum   = {1'b0, r_lp} + {1'b0, i_cmd.run};
    assign a1_s      = signed'({2'b00, v})
                       + signed'({{(POS_W-1){r_cmd.delta[2]}}, r_cmd.delta});
    assign rs        = (r_lp > i_width) ? i_width : r_lp;
    assign moves     = (r_cmd.kind != CMD_ERR);
    assign do_push   = ((r_cmd.kind == CMD_VERT) || (r_cmd.kind == CMD_RUN))
                       && (r_re < i_width) && (r_cur_count < POS_LIMIT);
    assign cur_next  = do_push ? (r_cur_count + 1'b1) : r_cur_count;
    assign row_end   = moves && ((r_cmd.kind != CMD_RUN) || r_cmd.second)
                       && (r_re >= i_width);

    assign o_stat.idle      = (r_state == BS_IDLE);
    assign o_stat.color     = r_color;
    assign o_stat.rows_done = rows_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid && !r_halt && !rows_done) begin
                    if ((i_cmd.kind == CMD_PASS) || (i_cmd.kind == CMD_VERT)) begin
                        n_state = BS_SCAN_RD;
                    end else begin
                        n_state = BS_EMIT;
                    end
                end
            end
            BS_SCAN_RD: n_state = BS_SCAN_CMP;
            BS_SCAN_CMP: begin
                if (!found) begin
                    n_state = BS_SCAN_RD;
                end else if ((r_cmd.kind == CMD_PASS) && (r_idx < r_ref_count)) begin
                    n_state = BS_B2_RD;
                end else begin
                    n_state = BS_EMIT;
                end
            end
            BS_B2_RD:  n_state = BS_B2_CMP;
            BS_B2_CMP: n_state = BS_EMIT;
            BS_EMIT: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = (r_state == BS_IDLE) && i_cmd_valid;
        rd_addr   = r_idx[IDX_W-1:0];
        wr_en     = emit && do_push;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_ref_sel) begin
            r_mem0[r_cur_count[IDX_W-1:0]] <= r_re;
        end
        r_rd0 <= r_mem0[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !r_ref_sel) begin
            r_mem1[r_cur_count[IDX_W-1:0]] <= r_re;
        end
        r_rd1 <= r_mem1[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                r_cmd <= i_cmd;
                r_idx <= '0;
                r_re  <= (run_sum > {1'b0, i_width}) ? i_width : run_sum[POS_W-1:0];
            end
            BS_SCAN_CMP: begin
                if (!found) begin
                    r_idx <= r_idx + 1'b1;
                end else if (r_cmd.kind == CMD_VERT) begin
                    if (a1_s < 0) begin
                        r_re <= '0;
                    end else if (a1_s > signed'({2'b00, i_width})) begin
                        r_re <= i_width;
                    end else begin
                        r_re <= a1_s[POS_W-1:0];
                    end
                end else if (r_idx < r_ref_count) begin
                    r_idx <= r_idx + 1'b1;
                end else begin
                    r_re <= i_width;
                end
            end
            BS_B2_CMP: r_re <= (v > i_width) ? i_width : v;
            default:   r_re <= r_re;
        endcase
        if (emit) begin
            r_o_start  <= rs;
            r_o_end    <= moves ? r_re : rs;
            r_o_black  <= r_color;
            r_o_row    <= r_row_count[ROW_W-1:0];
            r_o_done   <= row_end;
            if (!moves) begin
                r_o_status <= r_cmd.status;
            end else if ((r_cmd.kind == CMD_RUN) && !r_cmd.second && r_cmd.last) begin
                r_o_status <= ST_TRUNC;
            end else begin
                r_o_status <= ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_lp        <= '0;
            r_color     <= 1'b0;
            r_fresh     <= 1'b1;
            r_row_count <= '0;
            r_ref_sel   <= 1'b0;
            r_ref_count <= '0;
            r_cur_count <= '0;
            r_halt      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (emit) begin
                if (r_cmd.last || !moves) begin
                    r_halt <= 1'b1;
                end
                if (row_end) begin
                    r_ref_sel   <= ~r_ref_sel;
                    r_ref_count <= cur_next;
                    r_cur_count <= '0;
                    r_lp        <= '0;
                    r_color     <= 1'b0;
                    r_fresh     <= 1'b1;
                    r_row_count <= r_row_count + 1'b1;
                    if ((r_row_count + 1'b1) >= i_height) begin
                        r_halt <= 1'b1;
                    end
                end else if (moves) begin
                    r_cur_count <= cur_next;
                    r_lp        <= r_re;
                    r_fresh     <= 1'b0;
                    if (r_cmd.kind != CMD_PASS) begin
                        r_color <= ~r_color;
                    end
                end
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_run_start = r_o_start;
    assign o_run_end   = r_o_end;
    assign o_run_black = r_o_black;
    assign o_run_row   = r_o_row;
    assign o_row_done  = r_o_done;
    assign o_status    = r_o_status;

    `ASSERT_IMPLIES(a_done_only_ok, i_clk, i_rst_n, r_o_valid && r_o_done, r_o_status == ST_OK)
    `ASSERT_NEXT(a_halt_sticks, i_clk, i_rst_n, r_halt, r_halt)

endmodule
`default_nettype wire

[design/group4_fax_line_decoder_unit.sv]
// Path: each item goes from the command queue through the executor to the output
// register; vertical and pass items scan reference entries first, a pass may read b2.
// Throughput: one code bit per cycle while the command queue has room; after a
// horizontal code, intake holds until the executor is idle and the queue empty.
// Reset: synchronous, active low; change lists use fill counts, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module group4_fax_line_decoder_unit
    import g4fax_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_code_bit,
    input  wire logic             i_stream_end,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [POS_W-1:0]      o_run_start,
    output logic [POS_W-1:0]      o_run_end,
    output logic                  o_run_black,
    output logic [ROW_W-1:0]      o_run_row,
    output logic                  o_row_done,
    output logic [1:0]            o_status,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_index,
    input  wire logic [POS_W-1:0] i_cfg_data
);

    logic [POS_W-1:0] r_line_width;
    logic [POS_W-1:0] r_image_height;
    logic [POS_W-1:0] width;
    logic [POS_W-1:0] height;
    t_back_stat       stat;
    t_cmd             push_cmd;
    t_cmd             head_cmd;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default:          r_line_width   <= r_line_width;
            endcase
        end
    end

    assign width  = (r_line_width == '0) ? POS_W'(1)
                  : ((r_line_width > POS_LIMIT) ? POS_LIMIT : r_line_width);
    assign height = (r_image_height > POS_LIMIT) ? POS_LIMIT : r_image_height;

    g4fax_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_code_bit   (i_code_bit),
        .i_stream_end (i_stream_end),
        .i_stat       (stat),
        .i_full       (full),
        .i_empty      (empty),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    g4fax_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    g4fax_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!empty),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .i_width     (width),
        .i_height    (height),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_run_start (o_run_start),
        .o_run_end   (o_run_end),
        .o_run_black (o_run_black),
        .o_run_row   (o_run_row),
        .o_row_done  (o_row_done),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire
